// ===== src/pvec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvec_pkg
// Shared types and constants of the pixel variance exposure check.
// ----------------------------------------------------------------------------
package pvec_pkg;

  localparam int unsigned Q8W = 23;   // width of the variance result, q8
  localparam int unsigned FRACW = 8;  // fractional bits of the result
  localparam int unsigned BNDW = 16;  // width of a bound register

  localparam logic [BNDW-1:0] LOW_RESET = 16'd4000;
  localparam logic [BNDW-1:0] HIGH_RESET = 16'd12000;

  // register index, taken from paddr[2]
  localparam logic REG_LOW = 1'b0;
  localparam logic REG_HIGH = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_OVERFLOW = 2'd2
  } frame_status_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_MUL_NS,
    CS_MUL_SS,
    CS_SUB,
    CS_MUL_DEN,
    CS_DIV,
    CS_DONE
  } calc_state_e;

  // frame handover from the accumulator to the calculator
  typedef struct packed {
    logic          done;
    frame_status_e status;
  } frame_ctl_t;

  typedef struct packed {
    logic [Q8W-1:0] variance_q8;
    logic           exposure_ok;
    frame_status_e  frame_status;
  } result_t;

endpackage

// ===== src/pixel_variance_exposure_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_variance_exposure_check
// Frame variance (n-1 denominator, q8 fixed point) with an exposure window.
// ----------------------------------------------------------------------------
// Stream one frame of 8-bit pixels in, one beat per pixel, tlast on the final
// pixel; one result beat leaves per frame. While a frame is open the block
// takes a pixel every cycle. After the tlast beat the input stalls while one
// shared add/subtract unit works through the frame: it hands the frame over,
// forms n*S2 and S1*S1 by shift-add, subtracts, forms n*(n-1), runs a
// restoring division and posts the result. Too-short and overflowed frames
// skip the arithmetic. A result waits in an output register, so the next
// frame may start while it is unclaimed; the following frame's result holds
// until it is taken. Pixels beyond MAX_PIXELS are dropped and flag overflow.
// The bounds are whole-unit registers at 0x0 (low) and 0x4 (high), compared
// exactly.
// ----------------------------------------------------------------------------
module pixel_variance_exposure_check #(
  parameter int unsigned MAX_PIXELS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // pixel stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [7:0]                s_axis_tdata,   // [7:0] pixel
  input  logic                      s_axis_tlast,   // last_pixel
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [23:0]               m_axis_tdata,   // [22:0] variance_q8, [23] exposure_ok
  output logic [1:0]                m_axis_tuser,   // [1:0] frame_status
  // configuration
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import pvec_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);
  localparam int unsigned SW = CW + 8;
  localparam int unsigned QW = CW + 16;

  logic [BNDW-1:0] low_q, high_q;
  logic            cfg_wr;

  frame_ctl_t      ctl;
  logic [CW-1:0]   count;
  logic [SW-1:0]   sum;
  logic [QW-1:0]   sqsum;
  logic            calc_idle, clear, res_valid, take;
  result_t         res;

  logic            out_valid_q;
  result_t         out_q;

  // configuration registers; word-aligned, paddr[2] picks the register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LOW_RESET;
      high_q <= HIGH_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_LOW) begin
        low_q <= pwdata[BNDW-1:0];
      end else begin
        high_q <= pwdata[BNDW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LOW) begin
      prdata = 32'(low_q);
    end else begin
      prdata = 32'(high_q);
    end
    if (paddr[1:0] != 2'b00) begin
      prdata = '0;
    end
  end

  pvec_frame_acc #(
    .MAX_PIXELS (MAX_PIXELS),
    .CW         (CW),
    .SW         (SW),
    .QW         (QW)
  ) u_acc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .pixel_i     (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .calc_idle_i (calc_idle),
    .clear_i     (clear),
    .ready_o     (s_axis_tready),
    .ctl_o       (ctl),
    .count_o     (count),
    .sum_o       (sum),
    .sqsum_o     (sqsum)
  );

  pvec_calc #(
    .CW (CW),
    .SW (SW),
    .QW (QW)
  ) u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .count_i     (count),
    .sum_i       (sum),
    .sqsum_i     (sqsum),
    .low_i       (low_q),
    .high_i      (high_q),
    .take_i      (take),
    .idle_o      (calc_idle),
    .clear_o     (clear),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register: load when empty or when the held beat leaves
  assign take = res_valid && (!out_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.exposure_ok, out_q.variance_q8};
  assign m_axis_tuser  = out_q.frame_status;

endmodule

// ===== src/pvec_frame_acc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvec_frame_acc
// Per-frame pixel count, sum and sum of squares, one pixel per cycle while the calculator is idle.
// ----------------------------------------------------------------------------
module pvec_frame_acc #(
  parameter int unsigned MAX_PIXELS = 4096,
  parameter int unsigned CW = 13,
  parameter int unsigned SW = 21,
  parameter int unsigned QW = 29
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [7:0]            pixel_i,
  input  logic                  last_i,
  input  logic                  calc_idle_i,
  input  logic                  clear_i,
  output logic                  ready_o,
  output pvec_pkg::frame_ctl_t  ctl_o,
  output logic [CW-1:0]         count_o,
  output logic [SW-1:0]         sum_o,
  output logic [QW-1:0]         sqsum_o
);
  import pvec_pkg::*;

  logic [CW-1:0] count_q;
  logic [SW-1:0] sum_q;
  logic [QW-1:0] sqsum_q;
  logic          ovf_q;
  logic          done_q;
  logic          accept;
  logic [15:0]   square;

  assign ready_o = calc_idle_i && !done_q;
  assign accept  = valid_i && ready_o;
  assign square  = 16'(pixel_i) * 16'(pixel_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      sqsum_q <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else if (clear_i) begin
      count_q <= '0;
      sum_q   <= '0;
      sqsum_q <= '0;
      ovf_q   <= 1'b0;
      done_q  <= 1'b0;
    end else if (accept) begin
      // drop pixels past the frame limit, but keep the end mark
      if (count_q < CW'(MAX_PIXELS)) begin
        count_q <= count_q + CW'(1);
        sum_q   <= sum_q + SW'(pixel_i);
        sqsum_q <= sqsum_q + QW'(square);
      end else begin
        ovf_q <= 1'b1;
      end
      done_q <= last_i;
    end
  end

  always_comb begin
    ctl_o.done = done_q;
    if (ovf_q) begin
      ctl_o.status = ST_OVERFLOW;
    end else if (count_q < CW'(2)) begin
      ctl_o.status = ST_SHORT;
    end else begin
      ctl_o.status = ST_OK;
    end
  end

  assign count_o = count_q;
  assign sum_o   = sum_q;
  assign sqsum_o = sqsum_q;

endmodule

// ===== src/pvec_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvec_calc
// Sequencer around one shared add/subtract unit: shift-add products,
// restoring division and the bound check for one frame.
// ----------------------------------------------------------------------------
module pvec_calc #(
  parameter int unsigned CW = 13,
  parameter int unsigned SW = 21,
  parameter int unsigned QW = 29
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pvec_pkg::frame_ctl_t          ctl_i,
  input  logic [CW-1:0]                 count_i,
  input  logic [SW-1:0]                 sum_i,
  input  logic [QW-1:0]                 sqsum_i,
  input  logic [pvec_pkg::BNDW-1:0]     low_i,
  input  logic [pvec_pkg::BNDW-1:0]     high_i,
  input  logic                          take_i,
  output logic                          idle_o,
  output logic                          clear_o,
  output logic                          res_valid_o,
  output pvec_pkg::result_t             res_o
);
  import pvec_pkg::*;

  localparam int unsigned NW = 2 * CW + 16;  // numerator width
  localparam int unsigned DW = 2 * CW;       // denominator width
  localparam int unsigned SH = Q8W - FRACW;  // low numerator bits shifted in during the division
  localparam int unsigned CNT_MAX = (SW > Q8W) ? SW : Q8W;
  localparam int unsigned CNTW = $clog2(CNT_MAX);
  localparam int unsigned IW = Q8W - FRACW;

  calc_state_e state_q, state_d;

  logic [NW-1:0]   acc_q, prod_q, mcand_q;
  logic [SW-1:0]   mplier_q;
  logic [CNTW-1:0] cnt_q;
  logic [DW-1:0]   rem_q, den_q;
  logic [Q8W-1:0]  dsh_q, quot_q;
  frame_status_e   status_q;

  logic [NW:0]     add_a, add_b, add_res;
  logic            add_sub;
  logic [NW-1:0]   acc_nx;
  logic            borrow;
  logic            last_step;
  logic [IW-1:0]   int_part;
  logic            ok;

  // shared unit
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (state_q)
      CS_MUL_NS, CS_MUL_SS, CS_MUL_DEN: begin
        add_a = {1'b0, acc_q};
        add_b = {1'b0, mcand_q};
      end
      CS_SUB: begin
        add_a   = {1'b0, prod_q};
        add_b   = {1'b0, acc_q};
        add_sub = 1'b1;
      end
      CS_DIV: begin
        add_a   = (NW + 1)'({rem_q, dsh_q[Q8W-1]});
        add_b   = (NW + 1)'(den_q);
        add_sub = 1'b1;
      end
      default: begin
        add_sub = 1'b0;
      end
    endcase
    add_res = add_sub ? (add_a - add_b) : (add_a + add_b);
  end

  assign acc_nx    = mplier_q[0] ? add_res[NW-1:0] : acc_q;
  assign borrow    = add_res[NW];
  assign last_step = (cnt_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (ctl_i.done) begin
          state_d = (ctl_i.status == ST_OK) ? CS_MUL_NS : CS_DONE;
        end
      end
      CS_MUL_NS: begin
        if (last_step) state_d = CS_MUL_SS;
      end
      CS_MUL_SS: begin
        if (last_step) state_d = CS_SUB;
      end
      CS_SUB: begin
        state_d = CS_MUL_DEN;
      end
      CS_MUL_DEN: begin
        if (last_step) state_d = CS_DIV;
      end
      CS_DIV: begin
        if (last_step) state_d = CS_DONE;
      end
      CS_DONE: begin
        if (take_i) state_d = CS_IDLE;
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      CS_IDLE: begin
        if (ctl_i.done) begin
          status_q <= ctl_i.status;
          acc_q    <= '0;
          mcand_q  <= NW'(sqsum_i);
          mplier_q <= SW'(count_i);
          cnt_q    <= CNTW'(CW - 1);
          quot_q   <= '0;
          rem_q    <= '0;
        end
      end
      CS_MUL_NS: begin
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        cnt_q    <= cnt_q - CNTW'(1);
        acc_q    <= acc_nx;
        if (last_step) begin
          prod_q   <= acc_nx;
          acc_q    <= '0;
          mcand_q  <= NW'(sum_i);
          mplier_q <= sum_i;
          cnt_q    <= CNTW'(SW - 1);
        end
      end
      CS_MUL_SS: begin
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        cnt_q    <= cnt_q - CNTW'(1);
        acc_q    <= acc_nx;
      end
      CS_SUB: begin
        prod_q   <= add_res[NW-1:0];
        acc_q    <= '0;
        mcand_q  <= NW'(count_i);
        mplier_q <= SW'(count_i - CW'(1));
        cnt_q    <= CNTW'(CW - 1);
      end
      CS_MUL_DEN: begin
        mcand_q  <= mcand_q << 1;
        mplier_q <= mplier_q >> 1;
        cnt_q    <= cnt_q - CNTW'(1);
        acc_q    <= acc_nx;
        if (last_step) begin
          // quotient fits Q8W bits, so the upper numerator bits stay below den
          den_q <= acc_nx[DW-1:0];
          rem_q <= prod_q[SH +: DW];
          dsh_q <= {prod_q[SH-1:0], FRACW'(0)};
          cnt_q <= CNTW'(Q8W - 1);
        end
      end
      CS_DIV: begin
        rem_q  <= borrow ? {rem_q[DW-2:0], dsh_q[Q8W-1]} : add_res[DW-1:0];
        quot_q <= {quot_q[Q8W-2:0], ~borrow};
        dsh_q  <= dsh_q << 1;
        cnt_q  <= cnt_q - CNTW'(1);
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  // exact bound check from quotient and remainder
  assign int_part = quot_q[Q8W-1:FRACW];
  always_comb begin
    ok = (status_q == ST_OK)
      && (BNDW'(int_part) >= low_i)
      && ((BNDW'(int_part) < high_i)
          || ((BNDW'(int_part) == high_i) && (quot_q[FRACW-1:0] == '0)
              && (rem_q == '0)));
  end

  // outputs
  always_comb begin
    idle_o           = (state_q == CS_IDLE);
    res_valid_o      = (state_q == CS_DONE);
    clear_o          = (state_q == CS_DONE) && take_i;
    res_o.variance_q8  = quot_q;
    res_o.exposure_ok  = ok;
    res_o.frame_status = status_q;
  end

endmodule

// ===== tb/sv/frame_variance_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_variance_check
// Predicts and checks the frame variance results and the bound registers.
// ----------------------------------------------------------------------------
// Watch pixel beats, result beats and register accesses. Accumulate each
// frame, work out its expected result on the tlast beat, and compare every
// result beat field by field with the oldest expected result. Check register
// reads against the bounds last written.
// ----------------------------------------------------------------------------
module frame_variance_check #(
  parameter int unsigned MAX_PIXELS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic        s_axis_tlast,   // last_pixel
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,   // [22:0] variance_q8, [23] exposure_ok
  input  logic [1:0]  m_axis_tuser,   // [1:0] frame_status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int unsigned fail_count_o = 0,
  output int unsigned pending_o = 0,
  output int unsigned results_o = 0
);
  import pvec_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);

  logic [BNDW-1:0] bound_low, bound_high;
  logic [CW-1:0]   px_count;
  logic [CW+7:0]   px_sum;
  logic [CW+15:0]  sq_sum;
  logic            px_dropped;
  result_t         frame_results_q[$];

  // Grade one closed frame: status, q8 variance and window flag.
  function automatic result_t grade_frame(input logic [CW-1:0] count,
                                          input logic [CW+7:0] sum,
                                          input logic [CW+15:0] sq,
                                          input logic dropped,
                                          input logic [BNDW-1:0] lo,
                                          input logic [BNDW-1:0] hi);
    logic [63:0] n, num, den;
    result_t     r;
    r = '0;
    r.frame_status = ST_OK;
    if (dropped) begin
      r.frame_status = ST_OVERFLOW;
    end else if (count < 2) begin
      r.frame_status = ST_SHORT;
    end else begin
      n   = 64'(count);
      num = n * 64'(sq) - 64'(sum) * 64'(sum);
      den = n * (n - 64'd1);
      r.variance_q8 = Q8W'((num << FRACW) / den);
      r.exposure_ok = (64'(lo) * den <= num) && (num <= 64'(hi) * den);
    end
    return r;
  endfunction

  task automatic report(input string what, input longint unsigned exp_v,
                        input longint unsigned act_v);
    fail_count_o++;
    $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, what, exp_v, act_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      bound_low  = LOW_RESET;
      bound_high = HIGH_RESET;
      px_count   = '0;
      px_sum     = '0;
      sq_sum     = '0;
      px_dropped = 1'b0;
      frame_results_q.delete();
      pending_o = 0;
    end else begin
      // register accesses
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_LOW) bound_low = pwdata[BNDW-1:0];
          else bound_high = pwdata[BNDW-1:0];
        end else begin
          report_read: begin
            logic [31:0] want_rd;
            want_rd = {16'd0, (paddr[2] == REG_LOW) ? bound_low : bound_high};
            if (prdata !== want_rd) report("prdata", want_rd, prdata);
          end
        end
      end

      // result beats
      if (m_axis_tvalid && m_axis_tready) begin
        results_o++;
        if (frame_results_q.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: result beat with none expected: expected nothing, actual %h/%h",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = frame_results_q.pop_front();
          if (m_axis_tdata[22:0] !== want.variance_q8)
            report("variance_q8", want.variance_q8, m_axis_tdata[22:0]);
          if (m_axis_tdata[23] !== want.exposure_ok)
            report("exposure_ok", want.exposure_ok, m_axis_tdata[23]);
          if (m_axis_tuser !== want.frame_status)
            report("frame_status", want.frame_status, m_axis_tuser);
        end
      end

      // pixel beats; drop pixels once the frame is full
      if (s_axis_tvalid && s_axis_tready) begin
        if (px_count < MAX_PIXELS) begin
          px_count = px_count + 1'b1;
          px_sum   = px_sum + s_axis_tdata;
          sq_sum   = sq_sum + s_axis_tdata * s_axis_tdata;
        end else begin
          px_dropped = 1'b1;
        end
        if (s_axis_tlast) begin
          frame_results_q.push_back(grade_frame(px_count, px_sum, sq_sum, px_dropped,
                                                bound_low, bound_high));
          px_count   = '0;
          px_sum     = '0;
          sq_sum     = '0;
          px_dropped = 1'b0;
        end
      end
      pending_o = frame_results_q.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the pixel variance exposure check.
// ----------------------------------------------------------------------------
// Drive pixel frames into the block in random bursts while the result side
// stalls on its own pattern; reprogram the variance window between frames.
// A directed part covers short frames, full and overflowing frames, extreme
// pixels and exact window edges; a random part covers several window
// settings, a long result hold-off and a full drain. The checker module
// predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module testbench;
  import pvec_pkg::*;

  localparam int unsigned MAX_PIXELS = 4096;
  localparam int unsigned HOLD_CYCLES = 400;

  typedef enum int unsigned {
    MIX_UNIFORM,
    MIX_NARROW,
    MIX_EXTREME,
    MIX_FLAT,
    MIX_ALTERNATE,
    MIX_FULL
  } pixel_mix_e;

  typedef enum int unsigned {
    RX_OPEN,
    RX_RANDOM,
    RX_SPARSE,
    RX_PERIODIC
  } rx_pattern_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [7:0]  s_axis_tdata;    // [7:0] pixel
  logic        m_axis_tvalid, m_axis_tready;
  logic [23:0] m_axis_tdata;    // [22:0] variance_q8, [23] exposure_ok
  logic [1:0]  m_axis_tuser;    // [1:0] frame_status
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  int unsigned fail_count, frames_pending, results_seen;

  // stimulus bookkeeping
  int unsigned n_pixels = 0, n_frames = 0, n_short = 0, n_over = 0, n_cfg = 0;
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;
  int unsigned hold_reqs = 0;   // bumped by the stimulus, served by the receiver

  always #6 clk_i = ~clk_i;

  pixel_variance_exposure_check #(.MAX_PIXELS(MAX_PIXELS)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  frame_variance_check #(.MAX_PIXELS(MAX_PIXELS)) u_check (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_count_o(fail_count), .pending_o(frames_pending), .results_o(results_seen)
  );

  // --------------------------------------------------------------------------
  // Sender side helpers. Every pixel task starts at a falling edge and assigns
  // tvalid there exactly once, so a beat that was just taken never lingers
  // into the next rising edge.
  // --------------------------------------------------------------------------

  // Hold the pixel stream idle; n sets how long.
  task automatic rest(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
  endtask

  // Offer one pixel beat and wait for the handshake; insert a random gap
  // at the start of each burst while gaps_on is set.
  task automatic send_beat(input logic [7:0] px, input logic last);
    if (burst_left == 0) begin
      if (gaps_on)
        rest(($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5));
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = px;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    n_pixels++;
  endtask

  // Send a whole frame; pixel content follows the chosen mix.
  task automatic send_frame(input int unsigned len, input pixel_mix_e mix);
    logic [7:0]  centre, px;
    int unsigned i;
    centre = 8'($urandom());
    for (i = 1; i <= len; i++) begin
      case (mix)
        MIX_UNIFORM:   px = 8'($urandom());
        MIX_NARROW:    px = centre + 8'($urandom_range(0, 15));
        MIX_EXTREME:   px = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
        MIX_FLAT:      px = centre;
        MIX_ALTERNATE: px = i[0] ? 8'hFF : 8'h00;
        default:       px = 8'hFF;
      endcase
      send_beat(px, i == len);
    end
    n_frames++;
    if (len < 2) n_short++;
    else if (len > MAX_PIXELS) n_over++;
  endtask

  // Two-pixel frame with chosen content; its variance is (a-b)^2/2.
  task automatic send_pair(input logic [7:0] a, input logic [7:0] b);
    send_beat(a, 1'b0);
    send_beat(b, 1'b1);
    n_frames++;
  endtask

  // Stop sending until every expected result has come, then let the
  // calculator settle before touching the registers.
  task automatic drain();
    rest(1);
    while (frames_pending != 0) rest(1);
    rest(12);
  endtask

  // One APB transfer: setup cycle, access cycle, then release the bus.
  task automatic apb_xfer(input logic wr, input logic sel, input logic [15:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {sel, 2'b00};
    pwdata  = {16'($urandom()), value};   // junk above the register width
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Reprogram the window while the block is idle and read both bounds back.
  task automatic set_bounds(input logic [15:0] lo, input logic [15:0] hi);
    drain();
    apb_xfer(1'b1, REG_LOW, lo);
    apb_xfer(1'b1, REG_HIGH, hi);
    apb_xfer(1'b0, REG_LOW, 16'd0);
    apb_xfer(1'b0, REG_HIGH, 16'd0);
    n_cfg++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall on a pattern of its own, switching between wide-open,
  // random, sparse and periodic stretches. Serve a hold-off request by
  // keeping tready low while a hold counter loaded from HOLD_CYCLES runs down.
  // --------------------------------------------------------------------------
  initial begin : receiver
    rx_pattern_e pattern;
    int unsigned stretch, hold, served, cyc;
    pattern = RX_OPEN;
    stretch = 0;
    hold    = 0;
    served  = 0;
    cyc     = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_reqs != served) begin
        served++;
        hold = HOLD_CYCLES;
      end
      if (hold != 0) begin
        hold--;
        m_axis_tready = 1'b0;
      end else begin
        if (stretch == 0) begin
          pattern = rx_pattern_e'($urandom_range(0, 3));
          stretch = $urandom_range(20, 300);
        end
        stretch--;
        case (pattern)
          RX_OPEN:     m_axis_tready = 1'b1;
          RX_RANDOM:   m_axis_tready = ($urandom_range(0, 9) < 7);
          RX_SPARSE:   m_axis_tready = ($urandom_range(0, 3) == 0);
          default:     m_axis_tready = ((cyc % 7) < 3);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned phase, frames_in_phase, stop_at, len, pick;
    pixel_mix_e  mix;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'd0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = 3'd0;
    pwdata        = 32'd0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    rest(3);

    // Directed: short frames, extreme pixels, reset window.
    send_frame(1, MIX_FLAT);          // single pixel: too short
    send_pair(8'h00, 8'hFF);          // largest variance
    send_pair(8'hFF, 8'hFF);          // zero variance
    send_pair(8'h00, 8'd150);         // inside the reset window
    send_frame(1, MIX_FULL);
    send_frame(3, MIX_EXTREME);

    // Exact window edges: 0,100 gives exactly 5000; 0,101 gives 5100.5.
    set_bounds(16'd5000, 16'd5000);
    send_pair(8'd0, 8'd100);
    send_pair(8'd100, 8'd0);
    set_bounds(16'd5001, 16'd65535);
    send_pair(8'd0, 8'd100);
    set_bounds(16'd0, 16'd4999);
    send_pair(8'd0, 8'd100);
    set_bounds(16'd5100, 16'd5100);
    send_pair(8'd0, 8'd101);
    set_bounds(16'd5100, 16'd5101);
    send_pair(8'd0, 8'd101);

    // Full and overflowing frames; run them without sender gaps.
    set_bounds(LOW_RESET, HIGH_RESET);
    gaps_on = 1'b0;
    send_frame(MAX_PIXELS, MIX_ALTERNATE);      // alternating extremes, still fits
    send_frame(MAX_PIXELS, MIX_FULL);
    send_frame(MAX_PIXELS + 1, MIX_UNIFORM);    // marked pixel itself dropped
    send_frame(MAX_PIXELS + 4, MIX_FULL);
    gaps_on = 1'b1;
    send_pair(8'd7, 8'd200);                    // frame after overflow starts clean

    // Random part: one window setting per phase.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_bounds(16'd0, 16'd65535);
        1: set_bounds(16'd65535, 16'd0);        // crossed: nothing passes
        2: set_bounds(16'($urandom_range(0, 8000)), 16'($urandom_range(8000, 20000)));
        3: set_bounds(16'd0, 16'd0);
        4: set_bounds(16'd32768, 16'd65535);    // above any reachable variance
        default: set_bounds(16'($urandom()), 16'($urandom()));
      endcase
      gaps_on = (phase != 4);
      frames_in_phase = 0;
      stop_at = n_pixels + 150;
      while (n_pixels < stop_at) begin
        // Hold the result side off while short frames keep coming, so the
        // output register and the calculator fill and the input stalls.
        if (phase == 2 && frames_in_phase == 3) hold_reqs++;
        // Pause the sender until every result is back, then go on.
        if (phase == 3 && frames_in_phase == 5) drain();

        pick = $urandom_range(0, 19);
        if (phase == 2 && frames_in_phase >= 3 && frames_in_phase < 10)
          len = $urandom_range(2, 4);
        else if (pick < 2) len = 1;
        else if (pick < 3) len = $urandom_range(25, 200);
        else len = $urandom_range(2, 24);

        pick = $urandom_range(0, 19);
        if (pick < 8) mix = MIX_UNIFORM;
        else if (pick < 14) mix = MIX_NARROW;
        else if (pick < 17) mix = MIX_EXTREME;
        else if (pick < 19) mix = MIX_FLAT;
        else mix = MIX_ALTERNATE;

        send_frame(len, mix);
        frames_in_phase++;
      end
    end

    // Wait for the last results, then give the block time to misbehave.
    rest(1);
    while (frames_pending != 0) rest(1);
    rest(100);

    $display("Run covered %0d pixels in %0d frames (%0d too short, %0d overflowed)",
             n_pixels, n_frames, n_short, n_over);
    $display("%0d results checked across %0d window settings", results_seen, n_cfg);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #20_000_000;
    $display("Timeout: results still outstanding");
    $display("Test completed with failures");
    $finish;
  end

endmodule
